// ===== hdl/ws2812_pkg.sv =====
// shared types and constants of the ws2812 chain driver
`default_nettype none
package ws2812_pkg;

    // chain length and frame store geometry
    localparam int LED_COUNT = 64;
    localparam int LED_AW    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int IDX_W     = 8;
    localparam int WORD_W    = 24;
    localparam int BIT_W     = 5;
    localparam int TICK_W    = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [BIT_W-1:0]  BIT_LAST = BIT_W'(WORD_W - 1);
    localparam logic [LED_AW-1:0] LED_LAST = LED_AW'(LED_COUNT - 1);

    // configuration register reset values
    localparam logic [TICK_W-1:0] PERIOD_RST    = 10'd125;
    localparam logic [TICK_W-1:0] ONE_HIGH_RST  = 10'd83;
    localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 10'd41;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD    = 2'd0,
        CFG_ONE_HIGH  = 2'd1,
        CFG_ZERO_HIGH = 2'd2,
        CFG_UNUSED    = 2'd3
    } t_cfg_idx;

    // request codes
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_START = 2'd2,
        REQ_NOP   = 2'd3
    } t_req;

    // how the pin level of a result is formed
    typedef enum logic [1:0] {
        PIN_HOLD = 2'd0,
        PIN_LOW  = 2'd1,
        PIN_WAVE = 2'd2
    } t_pin_op;

    // control handed from the sequencer to the pin stage
    typedef struct packed {
        t_pin_op           pin_op;
        logic [BIT_W-1:0]  bit_pos;
        logic [TICK_W-1:0] tick_cnt;
        logic              busy;
        logic              done;
        logic              rej;
    } t_s1_ctl;

endpackage
`default_nettype wire

// ===== hdl/ws2812_frame_store.sv =====
// frame store: one grb word per led, synchronous read, valid bits for reset
`default_nettype none
module ws2812_frame_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_we,
    input  wire logic [ws2812_pkg::LED_AW-1:0] i_waddr,
    input  wire logic [ws2812_pkg::WORD_W-1:0] i_wdata,
    input  wire logic                          i_re,
    input  wire logic [ws2812_pkg::LED_AW-1:0] i_raddr,
    output logic      [ws2812_pkg::WORD_W-1:0] o_rdata
);
    import ws2812_pkg::*;

    logic [WORD_W-1:0]    r_mem [LED_COUNT];
    logic [LED_COUNT-1:0] r_vld;
    logic [WORD_W-1:0]    r_rdata;
    logic                 r_rd_vld;

    // storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // valid bits, cleared at reset so unwritten leds read as off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_vld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_vld ? r_rdata : '0;

endmodule
`default_nettype wire

// ===== hdl/ws2812_seq.sv =====
// request decode and frame position counters
`default_nettype none
module ws2812_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [1:0]                    i_req_type,
    input  wire logic [ws2812_pkg::IDX_W-1:0]  i_led_index,
    input  wire logic [7:0]                    i_green,
    input  wire logic [7:0]                    i_red,
    input  wire logic [7:0]                    i_blue,
    input  wire logic [ws2812_pkg::TICK_W-1:0] i_bit_period,
    output ws2812_pkg::t_s1_ctl                o_ctl,
    output logic                               o_we,
    output logic      [ws2812_pkg::LED_AW-1:0] o_waddr,
    output logic      [ws2812_pkg::WORD_W-1:0] o_wdata,
    output logic      [ws2812_pkg::LED_AW-1:0] o_raddr
);
    import ws2812_pkg::*;

    logic [LED_AW-1:0] r_led_pos, n_led_pos;
    logic [BIT_W-1:0]  r_bit_pos, n_bit_pos;
    logic [TICK_W-1:0] r_tick_cnt, n_tick_cnt;
    logic              r_sending, n_sending;
    logic [TICK_W:0]   w_tick_inc;
    logic              w_bit_end;
    logic              w_idx_bad;

    assign w_tick_inc = {1'b0, r_tick_cnt} + 1'b1;
    assign w_bit_end  = w_tick_inc >= {1'b0, i_bit_period};
    assign w_idx_bad  = {1'b0, i_led_index} >= (IDX_W + 1)'(LED_COUNT);

    // store access for the current transfer
    assign o_waddr = i_led_index[LED_AW-1:0];
    assign o_wdata = {i_green, i_red, i_blue};
    assign o_raddr = r_led_pos;

    // next position and result control
    always_comb begin
        n_led_pos      = r_led_pos;
        n_bit_pos      = r_bit_pos;
        n_tick_cnt     = r_tick_cnt;
        n_sending      = r_sending;
        o_we           = 1'b0;
        o_ctl.pin_op   = PIN_HOLD;
        o_ctl.bit_pos  = r_bit_pos;
        o_ctl.tick_cnt = r_tick_cnt;
        o_ctl.done     = 1'b0;
        o_ctl.rej      = 1'b0;
        unique case (t_req'(i_req_type))
            REQ_TICK: begin
                if (r_sending) begin
                    o_ctl.pin_op = PIN_WAVE;
                    if (w_bit_end) begin
                        n_tick_cnt = '0;
                        if (r_bit_pos == BIT_LAST) begin
                            n_bit_pos = '0;
                            if (r_led_pos == LED_LAST) begin
                                n_led_pos    = '0;
                                n_sending    = 1'b0;
                                o_ctl.pin_op = PIN_LOW;
                                o_ctl.done   = 1'b1;
                            end else begin
                                n_led_pos = r_led_pos + 1'b1;
                            end
                        end else begin
                            n_bit_pos = r_bit_pos + 1'b1;
                        end
                    end else begin
                        n_tick_cnt = w_tick_inc[TICK_W-1:0];
                    end
                end else begin
                    o_ctl.pin_op = PIN_LOW;
                end
            end
            REQ_WRITE: begin
                if (r_sending || w_idx_bad) begin
                    o_ctl.rej = 1'b1;
                end else begin
                    o_we = i_accept;
                end
            end
            REQ_START: begin
                if (r_sending) begin
                    o_ctl.rej = 1'b1;
                end else begin
                    n_sending    = 1'b1;
                    n_led_pos    = '0;
                    n_bit_pos    = '0;
                    n_tick_cnt   = '0;
                    o_ctl.pin_op = PIN_LOW;
                end
            end
            REQ_NOP: begin
            end
        endcase
        o_ctl.busy = n_sending;
    end

    // position registers advance on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_pos  <= '0;
            r_bit_pos  <= '0;
            r_tick_cnt <= '0;
            r_sending  <= 1'b0;
        end else if (i_accept) begin
            r_led_pos  <= n_led_pos;
            r_bit_pos  <= n_bit_pos;
            r_tick_cnt <= n_tick_cnt;
            r_sending  <= n_sending;
        end
    end

`ifndef ASSERT_OFF
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_pos <= BIT_LAST)
        else $error("bit position past last bit");
    a_led_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_led_pos <= LED_LAST)
        else $error("led position past end of chain");
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> !r_sending && i_accept)
        else $error("frame store written during a frame");
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !r_sending && t_req'(i_req_type) == REQ_START)
        |=> r_sending && r_tick_cnt == '0 && r_bit_pos == '0)
        else $error("start did not reset frame position");
`endif

endmodule
`default_nettype wire

// ===== hdl/ws2812_led_chain_driver.sv =====
// top level of the ws2812 chain driver: config, pin stage and output register
`default_nettype none
// Drives a ws2812 chain on one pin from a frame store of LED_COUNT grb words.
// Requests (tick, pixel write, start) are taken one per cycle back to back
// while o_in_ready is high; each transfer yields one result: the sequencer
// updates the frame position and reads the current led word from the frame
// store, which registers it beside the pin stage control register, and the pin
// level is formed from the registered read data and lands in the output
// register. The store reads as zero after reset through per-entry valid bits,
// so there is no clearing pass. Configuration writes take effect at the next
// transfer and belong in idle periods.
module ws2812_led_chain_driver (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [ws2812_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ws2812_pkg::TICK_W-1:0]    i_cfg_wdata,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [1:0]                       i_req_type,
    input  wire logic [ws2812_pkg::IDX_W-1:0]     i_led_index,
    input  wire logic [7:0]                       i_green,
    input  wire logic [7:0]                       i_red,
    input  wire logic [7:0]                       i_blue,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_data_out,
    output logic                                  o_busy_res,
    output logic                                  o_frame_done,
    output logic                                  o_rejected
);
    import ws2812_pkg::*;

    logic [TICK_W-1:0] r_period, r_one_high, r_zero_high;
    t_s1_ctl           w_ctl;
    t_s1_ctl           r_s1;
    logic              r_s1_vld;
    logic              r_out_vld;
    logic              r_out_pin;
    logic              r_out_busy;
    logic              r_out_done;
    logic              r_out_rej;
    logic              w_accept;
    logic              w_out_free;
    logic              w_s1_move;
    logic              w_we;
    logic [LED_AW-1:0] w_waddr;
    logic [LED_AW-1:0] w_raddr;
    logic [WORD_W-1:0] w_wdata;
    logic [WORD_W-1:0] w_word;
    logic [BIT_W-1:0]  w_bit_sel;
    logic [TICK_W-1:0] w_high;
    logic              w_pin;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= PERIOD_RST;
            r_one_high  <= ONE_HIGH_RST;
            r_zero_high <= ZERO_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PERIOD:    r_period    <= i_cfg_wdata;
                CFG_ONE_HIGH:  r_one_high  <= i_cfg_wdata;
                CFG_ZERO_HIGH: r_zero_high <= i_cfg_wdata;
                CFG_UNUSED:    begin
                end
            endcase
        end
    end

    // pipeline flow control
    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_s1_move  = r_s1_vld && w_out_free;
    assign o_in_ready = !r_s1_vld || w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    ws2812_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_req_type   (i_req_type),
        .i_led_index  (i_led_index),
        .i_green      (i_green),
        .i_red        (i_red),
        .i_blue       (i_blue),
        .i_bit_period (r_period),
        .o_ctl        (w_ctl),
        .o_we         (w_we),
        .o_waddr      (w_waddr),
        .o_wdata      (w_wdata),
        .o_raddr      (w_raddr)
    );

    ws2812_frame_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_raddr),
        .o_rdata (w_word)
    );

    // pin stage control register, aligned with the store read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_accept) begin
            r_s1_vld <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= w_ctl;
        end
    end

    // waveform level for the current bit
    assign w_bit_sel = BIT_LAST - r_s1.bit_pos;
    assign w_high    = w_word[w_bit_sel] ? r_one_high : r_zero_high;

    always_comb begin
        unique case (r_s1.pin_op)
            PIN_HOLD: w_pin = r_out_pin;
            PIN_LOW:  w_pin = 1'b0;
            PIN_WAVE: w_pin = r_s1.tick_cnt < w_high;
            default:  w_pin = 1'b0;
        endcase
    end

    // output register, also holds the pin level between results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_out_pin  <= 1'b0;
            r_out_busy <= 1'b0;
            r_out_done <= 1'b0;
            r_out_rej  <= 1'b0;
        end else begin
            if (w_s1_move) begin
                r_out_vld  <= 1'b1;
                r_out_pin  <= w_pin;
                r_out_busy <= r_s1.busy;
                r_out_done <= r_s1.done;
                r_out_rej  <= r_s1.rej;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_data_out   = r_out_pin;
    assign o_busy_res   = r_out_busy;
    assign o_frame_done = r_out_done;
    assign o_rejected   = r_out_rej;

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_done) |-> (!r_out_busy && !r_out_pin))
        else $error("frame done while busy or pin high");
    a_done_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out_done && r_out_rej))
        else $error("frame done and rejected together");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_out_vld && !i_out_ready) |-> !o_in_ready)
        else $error("transfer taken with both stages full");
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !w_out_free) |=> r_s1_vld)
        else $error("pin stage item lost while stalled");
`endif

endmodule
`default_nettype wire

// ===== tb/ws2812_led_chain_driver_tb.sv =====
// self-checking testbench for the ws2812 chain driver: directed table, then random phases
`default_nettype none
module ws2812_led_chain_driver_tb;
    import ws2812_pkg::*;

    // one result: pin level, busy, frame done, rejected
    typedef struct packed {
        logic pin;
        logic busy;
        logic done;
        logic rej;
    } t_pin_result;

    typedef struct packed {
        t_req       req;
        logic [7:0] idx;
        logic [7:0] g;
        logic [7:0] r;
        logic [7:0] b;
    } t_chain_req;

    // directed row: request plus an optional typed-in result
    typedef struct packed {
        t_chain_req  rq;
        logic        has_exp;
        t_pin_result exp;
    } t_dir_row;

    localparam int N_DIR    = 21;
    localparam int N_PHASES = 5;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    t_cfg_idx           cfg_index = CFG_PERIOD;
    logic [TICK_W-1:0]  cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    t_req               req_type = REQ_TICK;
    logic [IDX_W-1:0]   led_index = '0;
    logic [7:0]         green = '0;
    logic [7:0]         red = '0;
    logic [7:0]         blue = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               data_out;
    logic               busy_res;
    logic               frame_done;
    logic               rejected;

    ws2812_led_chain_driver dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_req_type   (req_type),
        .i_led_index  (led_index),
        .i_green      (green),
        .i_red        (red),
        .i_blue       (blue),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_data_out   (data_out),
        .o_busy_res   (busy_res),
        .o_frame_done (frame_done),
        .o_rejected   (rejected)
    );

    // predictor copy of the block state and registers
    logic [WORD_W-1:0] frame_words [LED_COUNT];
    logic [7:0]        led_pos = '0;
    logic [BIT_W-1:0]  bit_pos = '0;
    logic [TICK_W-1:0] tick_cnt = '0;
    logic              frame_busy = 1'b0;
    logic              pin_q = 1'b0;
    logic [TICK_W-1:0] period_ticks = PERIOD_RST;
    logic [TICK_W-1:0] one_ticks = ONE_HIGH_RST;
    logic [TICK_W-1:0] zero_ticks = ZERO_HIGH_RST;

    t_pin_result pending_pin_results [$];
    int          mismatches = 0;
    int          burst_left = 0;

    // receiver stall pattern state
    int unsigned rx_cycle = 0;
    int          rx_mode = 0;
    logic [7:0]  rx_mask = 8'b1001_0110;

    // directed stimulus; result columns are pin, busy, done, rejected
    t_dir_row directed_rows [N_DIR] = '{
        '{'{REQ_TICK,  8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 4'b0000},
        '{'{REQ_NOP,   8'hff, 8'hff, 8'hff, 8'hff}, 1'b1, 4'b0000},
        '{'{REQ_WRITE, 8'h00, 8'hff, 8'hff, 8'hff}, 1'b1, 4'b0000},
        '{'{REQ_WRITE, 8'h3f, 8'h00, 8'h00, 8'h00}, 1'b1, 4'b0000},
        '{'{REQ_WRITE, 8'h40, 8'h12, 8'h34, 8'h56}, 1'b1, 4'b0001},
        '{'{REQ_WRITE, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1, 4'b0001},
        '{'{REQ_WRITE, 8'h01, 8'ha5, 8'h5a, 8'h0f}, 1'b1, 4'b0000},
        '{'{REQ_WRITE, 8'h02, 8'h80, 8'h00, 8'h01}, 1'b1, 4'b0000},
        '{'{REQ_TICK,  8'hff, 8'hff, 8'hff, 8'hff}, 1'b1, 4'b0000},
        '{'{REQ_START, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 4'b0100},
        '{'{REQ_START, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1, 4'b0101},
        '{'{REQ_WRITE, 8'h05, 8'h11, 8'h22, 8'h33}, 1'b1, 4'b0101},
        '{'{REQ_TICK,  8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 4'b1100},
        '{'{REQ_NOP,   8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 4'b1100},
        '{'{REQ_TICK,  8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 4'b0000},
        '{'{REQ_TICK,  8'haa, 8'h55, 8'haa, 8'h55}, 1'b0, 4'b0000},
        '{'{REQ_TICK,  8'h55, 8'haa, 8'h55, 8'haa}, 1'b0, 4'b0000},
        '{'{REQ_TICK,  8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 4'b0000},
        '{'{REQ_WRITE, 8'h40, 8'hff, 8'h00, 8'hff}, 1'b0, 4'b0000},
        '{'{REQ_START, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 4'b0000},
        '{'{REQ_TICK,  8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 4'b0000}
    };

    // register settings per random phase; the last one is drawn at random
    logic [TICK_W-1:0] ph_period [N_PHASES] = '{10'd1023, 10'd2, 10'd0, 10'd1, 10'd0};
    logic [TICK_W-1:0] ph_one    [N_PHASES] = '{10'd1022, 10'd1, 10'd1, 10'd1023, 10'd0};
    logic [TICK_W-1:0] ph_zero   [N_PHASES] = '{10'd1, 10'd1022, 10'd0, 10'd2, 10'd0};
    int                ph_items  [N_PHASES] = '{80, 120, 780, 800, 150};

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // advance the chain model by one request and return the pin result
    function automatic t_pin_result step_led_chain(t_chain_req rq);
        int          lp;
        int          bp;
        int          high;
        logic        bv;
        t_pin_result res;
        res.done = 1'b0;
        res.rej  = 1'b0;
        case (rq.req)
            REQ_TICK: begin
                if (frame_busy) begin
                    lp = (led_pos < LED_COUNT) ? int'(led_pos) : 0;
                    bp = (bit_pos < WORD_W) ? int'(bit_pos) : 0;
                    bv = frame_words[LED_AW'(lp)][BIT_W'(WORD_W - 1 - bp)];
                    high = bv ? int'(one_ticks) : int'(zero_ticks);
                    pin_q = (int'(tick_cnt) < high);
                    if (int'(tick_cnt) + 1 >= int'(period_ticks)) begin
                        tick_cnt = '0;
                        if (bp >= WORD_W - 1) begin
                            bit_pos = '0;
                            // last bit of the last led ends the frame with the pin low
                            if (lp + 1 >= LED_COUNT) begin
                                led_pos    = '0;
                                frame_busy = 1'b0;
                                pin_q      = 1'b0;
                                res.done   = 1'b1;
                            end else begin
                                led_pos = 8'(lp + 1);
                            end
                        end else begin
                            bit_pos = BIT_W'(bp + 1);
                        end
                    end else begin
                        tick_cnt = tick_cnt + 1'b1;
                    end
                end else begin
                    pin_q = 1'b0;
                end
            end
            REQ_WRITE: begin
                if (frame_busy || rq.idx >= LED_COUNT) begin
                    res.rej = 1'b1;
                end else begin
                    frame_words[rq.idx[LED_AW-1:0]] = {rq.g, rq.r, rq.b};
                end
            end
            REQ_START: begin
                if (frame_busy) begin
                    res.rej = 1'b1;
                end else begin
                    frame_busy = 1'b1;
                    led_pos    = '0;
                    bit_pos    = '0;
                    tick_cnt   = '0;
                    pin_q      = 1'b0;
                end
            end
            default: begin
            end
        endcase
        res.pin  = pin_q;
        res.busy = frame_busy;
        return res;
    endfunction

    // random request, mostly well-formed: fill while idle, tick while sending
    function automatic t_chain_req random_request();
        t_chain_req rq;
        int         pick;
        int         sel;
        rq.idx = 8'($urandom);
        rq.g   = 8'($urandom);
        rq.r   = 8'($urandom);
        rq.b   = 8'($urandom);
        pick   = $urandom_range(0, 99);
        if (frame_busy) begin
            if (pick < 97)       rq.req = REQ_TICK;
            else if (pick == 97) rq.req = REQ_WRITE;
            else if (pick == 98) rq.req = REQ_START;
            else                 rq.req = REQ_NOP;
        end else begin
            if (pick < 60)       rq.req = REQ_WRITE;
            else if (pick < 72)  rq.req = REQ_START;
            else if (pick < 92)  rq.req = REQ_TICK;
            else                 rq.req = REQ_NOP;
        end
        if (rq.req == REQ_WRITE) begin
            sel = $urandom_range(0, 9);
            if (sel < 8)       rq.idx = 8'($urandom_range(0, LED_COUNT - 1));
            else if (sel == 8) rq.idx = 8'($urandom_range(LED_COUNT, 255));
        end
        return rq;
    endfunction

    // present one request, hold it until the transfer, then record its result
    task automatic send_request(t_chain_req rq, logic use_typed, t_pin_result typed);
        int          gap;
        t_pin_result pred;
        gap = 0;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        req_type  <= rq.req;
        led_index <= rq.idx;
        green     <= rq.g;
        red       <= rq.r;
        blue      <= rq.b;
        do @(posedge i_clk); while (!in_ready);
        pred = step_led_chain(rq);
        pending_pin_results.push_back(use_typed ? typed : pred);
        burst_left--;
    endtask

    // drop valid and wait until every result is back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_pin_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one register write, mirrored into the predictor
    task automatic write_reg(t_cfg_idx idx, logic [TICK_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_PERIOD:    period_ticks = val;
            CFG_ONE_HIGH:  one_ticks    = val;
            CFG_ZERO_HIGH: zero_ticks   = val;
            default: begin
            end
        endcase
    endtask

    // receiver: ready pattern drawn at random from four modes
    always @(posedge i_clk) begin
        if (rx_cycle % 200 == 0) begin
            rx_mode = $urandom_range(0, 3);
        end
        rx_cycle++;
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 2) != 0);
            2: begin
                out_ready <= rx_mask[0];
                rx_mask = {rx_mask[0], rx_mask[7:1]};
            end
            default: out_ready <= (rx_cycle % 6 == 0);
        endcase
    end

    // result checker: each transfer against the oldest expectation
    t_pin_result got_res;
    t_pin_result exp_res;
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            got_res = {data_out, busy_res, frame_done, rejected};
            if (pending_pin_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: pin %0b busy %0b done %0b rej %0b",
                             got_res.pin, got_res.busy, got_res.done, got_res.rej);
                end
            end else begin
                exp_res = pending_pin_results.pop_front();
                if (got_res.pin !== exp_res.pin || got_res.busy !== exp_res.busy ||
                    got_res.done !== exp_res.done || got_res.rej !== exp_res.rej) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: pin %0b/%0b busy %0b/%0b done %0b/%0b rej %0b/%0b",
                                 exp_res.pin, got_res.pin, exp_res.busy, got_res.busy,
                                 exp_res.done, got_res.done, exp_res.rej, got_res.rej);
                    end
                end
            end
        end
    end

    // run limit
    initial begin
        #1_000_000;
        $display("ws2812_led_chain_driver regression: fail");
        $finish;
    end

    // main sequence: reset, directed table, register phases with random traffic
    initial begin
        foreach (frame_words[k]) frame_words[k] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            send_request(directed_rows[k].rq, directed_rows[k].has_exp, directed_rows[k].exp);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            if (ph == N_PHASES - 1) begin
                ph_period[ph] = TICK_W'($urandom_range(2, 12));
                ph_one[ph]    = TICK_W'($urandom_range(1, ph_period[ph] + 1));
                ph_zero[ph]   = TICK_W'($urandom_range(1, ph_period[ph] + 1));
            end
            write_reg(CFG_PERIOD, ph_period[ph]);
            write_reg(CFG_ONE_HIGH, ph_one[ph]);
            write_reg(CFG_ZERO_HIGH, ph_zero[ph]);
            // unused index must leave every register alone
            write_reg(CFG_UNUSED, TICK_W'($urandom_range(0, 1023)));
            cfg_we <= 1'b0;
            for (int n = 0; n < ph_items[ph]; n++) begin
                send_request(random_request(), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_pin_results.size() == 0) begin
            $display("ws2812_led_chain_driver regression: pass");
        end else begin
            $display("ws2812_led_chain_driver regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/ws2812_pkg.sv
hdl/ws2812_frame_store.sv
hdl/ws2812_seq.sv
hdl/ws2812_led_chain_driver.sv
tb/ws2812_led_chain_driver_tb.sv
